### rtl/binary_heap_priority_queue_defines.svh
// Assertion macros shared by the checker file.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define BHPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bhpq check failed");

// next-cycle implication, clocked on clk, off during reset
`define BHPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bhpq check failed");

`endif

### rtl/bhpq_pkg.sv
`default_nettype none
package bhpq_pkg;

  localparam int unsigned IW        = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 9;

  typedef enum logic [1:0] {
    ACT_INSERT     = 2'd0,
    ACT_REMOVE_TOP = 2'd1,
    ACT_REMOVE_AT  = 2'd2
  } action_t;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'b1;

  typedef struct packed {
    logic [1:0]          action;
    logic signed [31:0]  value;
    logic [7:0]          position;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [31:0]  removed_value;
    logic [8:0]          count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RM_RD_POS,
    S_RM_RD_LAST,
    S_RM_RD_PAR,
    S_RM_CMP,
    S_SU_RD,
    S_SU_CMP,
    S_SD_RD_L,
    S_SD_RD_R,
    S_SD_CMP_R,
    S_SD_CMP_H
  } state_t;

  function automatic logic ranks_above(input logic mode,
                                       input logic signed [31:0] a,
                                       input logic signed [31:0] b);
    ranks_above = mode ? (a > b) : (a < b);
  endfunction

endpackage
`default_nettype wire

### rtl/bhpq_ram.sv
`default_nettype none
module bhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/binary_heap_priority_queue.sv
`default_nettype none
// Binary heap priority queue of signed 32-bit values, min or max order by
// register. A request is taken when start is high and busy is low; its one
// result appears with out_strobe for a single cycle and cannot be stalled,
// so the receiver must take it then. Refused requests answer in the cycle
// after acceptance. An insert lets the new entry climb level by level. A
// removal that takes the last slot answers without moving entries, else the
// last entry moves into the freed slot and climbs or descends level by level.
// The strobe comes in the cycle after the last busy cycle. The cost per level
// comes from the heap RAM with one read port and registered read and the one
// comparator that every step shares. Back-to-back results are possible.
module binary_heap_priority_queue #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire bhpq_pkg::req_t                      in_req,
  output logic                                     out_strobe,
  output bhpq_pkg::rsp_t                           out_rsp,
  input  wire logic                                cfg_we,
  input  wire logic [bhpq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bhpq_pkg::CFG_W-1:0]          cfg_data
);
  import bhpq_pkg::*;

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned LIM_MAX = (DEPTH > 511) ? 511 : DEPTH;
  localparam logic [8:0]  LIM_CAP = 9'(LIM_MAX);

  state_t              state_r, state_nxt;
  logic [IW-1:0]       slot_r, slot_nxt;
  logic [IW-1:0]       best_idx_r, best_idx_nxt;
  logic signed [31:0]  held_r, held_nxt;
  logic signed [31:0]  best_r, best_nxt;
  logic signed [31:0]  removed_r, removed_nxt;
  logic [8:0]          count_r, count_nxt;
  logic                order_mode_r, order_mode_nxt;
  logic [8:0]          capacity_r, capacity_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  rsp_t                out_rsp_r, out_rsp_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [31:0]         ram_wdata, ram_rdata;
  logic signed [31:0]  rd_val;

  logic signed [31:0]  cmp_a, cmp_b;
  logic                cmp_hit;
  logic [8:0]          limit;
  logic [IW-1:0]       count_x, kid, kid_r1, parent;

  bhpq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_val  = ram_rdata;
  assign limit   = (capacity_r > LIM_CAP) ? LIM_CAP : capacity_r;
  assign count_x = IW'(count_r);
  assign kid     = {slot_r[IW-2:0], 1'b1};
  assign kid_r1  = kid + 1'b1;
  assign parent  = (slot_r - 1'b1) >> 1;
  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

  always_comb begin
    case (state_r)
      S_SD_CMP_R: begin
        cmp_a = rd_val;
        cmp_b = best_r;
      end
      S_SD_CMP_H: begin
        cmp_a = best_r;
        cmp_b = held_r;
      end
      default: begin
        cmp_a = held_r;
        cmp_b = rd_val;
      end
    endcase
    cmp_hit = ranks_above(order_mode_r, cmp_a, cmp_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      order_mode_r <= 1'b0;
      capacity_r   <= 9'd256;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      order_mode_r <= order_mode_nxt;
      capacity_r   <= capacity_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    slot_r     <= slot_nxt;
    best_idx_r <= best_idx_nxt;
    held_r     <= held_nxt;
    best_r     <= best_nxt;
    removed_r  <= removed_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    best_idx_nxt   = best_idx_r;
    held_nxt       = held_r;
    best_nxt       = best_r;
    removed_nxt    = removed_r;
    count_nxt      = count_r;
    order_mode_nxt = order_mode_r;
    capacity_nxt   = capacity_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(slot_r);
    ram_wdata      = held_r;
    ram_raddr      = AW'(slot_r);

    if (cfg_we) begin
      case (cfg_index)
        CFG_ORDER_MODE: order_mode_nxt = cfg_data[0];
        CFG_CAPACITY:   capacity_nxt   = cfg_data;
        default:        ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_rsp_nxt.removed_value = '0;
          out_rsp_nxt.count         = count_r;
          removed_nxt               = '0;
          case (in_req.action)
            ACT_INSERT: begin
              if (count_r >= limit) begin
                out_strobe_nxt     = 1'b1;
                out_rsp_nxt.status = ST_FULL;
              end else begin
                slot_nxt  = count_x;
                held_nxt  = in_req.value;
                count_nxt = count_r + 1'b1;
                state_nxt = S_SU_RD;
              end
            end
            ACT_REMOVE_TOP: begin
              if (count_r == '0) begin
                out_strobe_nxt     = 1'b1;
                out_rsp_nxt.status = ST_EMPTY;
              end else begin
                slot_nxt  = '0;
                count_nxt = count_r - 1'b1;
                state_nxt = S_RM_RD_POS;
              end
            end
            ACT_REMOVE_AT: begin
              if (count_r == '0) begin
                out_strobe_nxt     = 1'b1;
                out_rsp_nxt.status = ST_EMPTY;
              end else if ({1'b0, in_req.position} >= count_r) begin
                out_strobe_nxt     = 1'b1;
                out_rsp_nxt.status = ST_RANGE;
              end else begin
                slot_nxt  = IW'(in_req.position);
                count_nxt = count_r - 1'b1;
                state_nxt = S_RM_RD_POS;
              end
            end
            default: begin
              out_strobe_nxt     = 1'b1;
              out_rsp_nxt.status = ST_RANGE;
            end
          endcase
        end
      end
      S_RM_RD_POS: begin
        ram_raddr = AW'(slot_r);
        state_nxt = S_RM_RD_LAST;
      end
      S_RM_RD_LAST: begin
        removed_nxt = rd_val;
        if (slot_r >= count_x) begin
          state_nxt                 = S_IDLE;
          out_strobe_nxt            = 1'b1;
          out_rsp_nxt.status        = ST_DONE;
          out_rsp_nxt.removed_value = rd_val;
          out_rsp_nxt.count         = count_r;
        end else begin
          ram_raddr = AW'(count_x);
          state_nxt = S_RM_RD_PAR;
        end
      end
      S_RM_RD_PAR: begin
        held_nxt = rd_val;
        if (slot_r != '0) begin
          ram_raddr = AW'(parent);
          state_nxt = S_RM_CMP;
        end else begin
          state_nxt = S_SD_RD_L;
        end
      end
      S_RM_CMP: begin
        if (cmp_hit) begin
          ram_we    = 1'b1;
          ram_wdata = rd_val;
          slot_nxt  = parent;
          state_nxt = S_SU_RD;
        end else begin
          state_nxt = S_SD_RD_L;
        end
      end
      S_SU_RD: begin
        if (slot_r == '0) begin
          ram_we                    = 1'b1;
          state_nxt                 = S_IDLE;
          out_strobe_nxt            = 1'b1;
          out_rsp_nxt.status        = ST_DONE;
          out_rsp_nxt.removed_value = removed_r;
          out_rsp_nxt.count         = count_r;
        end else begin
          ram_raddr = AW'(parent);
          state_nxt = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        ram_we = 1'b1;
        if (cmp_hit) begin
          ram_wdata = rd_val;
          slot_nxt  = parent;
          state_nxt = S_SU_RD;
        end else begin
          state_nxt                 = S_IDLE;
          out_strobe_nxt            = 1'b1;
          out_rsp_nxt.status        = ST_DONE;
          out_rsp_nxt.removed_value = removed_r;
          out_rsp_nxt.count         = count_r;
        end
      end
      S_SD_RD_L: begin
        if (kid >= count_x) begin
          ram_we                    = 1'b1;
          state_nxt                 = S_IDLE;
          out_strobe_nxt            = 1'b1;
          out_rsp_nxt.status        = ST_DONE;
          out_rsp_nxt.removed_value = removed_r;
          out_rsp_nxt.count         = count_r;
        end else begin
          ram_raddr = AW'(kid);
          state_nxt = S_SD_RD_R;
        end
      end
      S_SD_RD_R: begin
        best_nxt     = rd_val;
        best_idx_nxt = kid;
        if (kid_r1 < count_x) begin
          ram_raddr = AW'(kid_r1);
          state_nxt = S_SD_CMP_R;
        end else begin
          state_nxt = S_SD_CMP_H;
        end
      end
      S_SD_CMP_R: begin
        if (cmp_hit) begin
          best_nxt     = rd_val;
          best_idx_nxt = kid_r1;
        end
        state_nxt = S_SD_CMP_H;
      end
      S_SD_CMP_H: begin
        ram_we = 1'b1;
        if (cmp_hit) begin
          ram_wdata = best_r;
          slot_nxt  = best_idx_r;
          state_nxt = S_SD_RD_L;
        end else begin
          state_nxt                 = S_IDLE;
          out_strobe_nxt            = 1'b1;
          out_rsp_nxt.status        = ST_DONE;
          out_rsp_nxt.removed_value = removed_r;
          out_rsp_nxt.count         = count_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/bhpq_checker.sv
`default_nettype none
`include "binary_heap_priority_queue_defines.svh"
module bhpq_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic                                busy,
  input  wire bhpq_pkg::req_t                      in_req,
  input  wire logic                                out_strobe,
  input  wire bhpq_pkg::rsp_t                      out_rsp,
  input  wire logic                                cfg_we,
  input  wire logic [bhpq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bhpq_pkg::CFG_W-1:0]          cfg_data
);
  import bhpq_pkg::*;

  logic unused_inputs;
  assign unused_inputs = ^{in_req, cfg_we, cfg_index, cfg_data};

  `BHPQ_ASSERT_NEXT(a_accept_answered, start && !busy, busy || out_strobe)
  `BHPQ_ASSERT_NOW(a_done_on_release, $fell(busy), out_strobe)
  `BHPQ_ASSERT_NOW(a_refused_no_value, out_strobe && out_rsp.status != ST_DONE,
                   out_rsp.removed_value == 0)
  `BHPQ_ASSERT_NOW(a_empty_means_zero, out_strobe && out_rsp.status == ST_EMPTY,
                   out_rsp.count == 0)

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (.*);
`default_nettype wire
